// ===== sv/jsu_pkg.sv =====
// Shared types, character constants and byte-level helpers of the JSON string unescaper.
package jsu_pkg;

  localparam int MAX_RES = 5;
  localparam int CNT_W   = 3;

  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_U   = 8'h75;
  localparam logic [7:0] CH_B   = 8'h62;
  localparam logic [7:0] CH_F   = 8'h66;
  localparam logic [7:0] CH_N   = 8'h6E;
  localparam logic [7:0] CH_R   = 8'h72;
  localparam logic [7:0] CH_T   = 8'h74;
  localparam logic [7:0] CC_BS  = 8'h08;
  localparam logic [7:0] CC_FF  = 8'h0C;
  localparam logic [7:0] CC_LF  = 8'h0A;
  localparam logic [7:0] CC_CR  = 8'h0D;
  localparam logic [7:0] CC_TAB = 8'h09;

  localparam logic [15:0] UTF_LIM1  = 16'h0080;
  localparam logic [15:0] UTF_LIM2  = 16'h0800;
  localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF_CONT  = 8'h80;
  localparam logic [7:0]  UTF_MASK  = 8'h3F;

  typedef enum logic [5:0] {
    MODE_NORMAL = 6'b000001,
    MODE_ESC    = 6'b000010,
    MODE_HEX0   = 6'b000100,
    MODE_HEX1   = 6'b001000,
    MODE_HEX2   = 6'b010000,
    MODE_HEX3   = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [CNT_W-1:0]        cnt;
    logic                    last;
  } cmd_t;

  function automatic logic [3:0] hex_value(logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    case (c) inside
      [8'h30:8'h39]:                v = c[3:0];
      [8'h61:8'h66], [8'h41:8'h46]: v = c[3:0] + 4'd9;
      default:                      v = 4'd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] translate(logic [7:0] e);
    logic [7:0] r;
    r = e;
    case (e)
      CH_B:    r = CC_BS;
      CH_F:    r = CC_FF;
      CH_N:    r = CC_LF;
      CH_R:    r = CC_CR;
      CH_T:    r = CC_TAB;
      default: r = e;
    endcase
    return r;
  endfunction

  function automatic cmd_t push_byte(cmd_t c, logic [7:0] b);
    cmd_t r;
    r = c;
    if (r.cnt < CNT_W'(MAX_RES)) begin
      r.bytes[r.cnt] = b;
      r.cnt          = r.cnt + CNT_W'(1);
    end
    return r;
  endfunction

  function automatic cmd_t push_utf8(cmd_t c, logic [15:0] cp);
    cmd_t r;
    r = c;
    if (cp < UTF_LIM1) begin
      r = push_byte(r, cp[7:0]);
    end else if (cp < UTF_LIM2) begin
      r = push_byte(r, UTF_LEAD2 | {3'b000, cp[10:6]});
      r = push_byte(r, UTF_CONT | ({2'b00, cp[5:0]} & UTF_MASK));
    end else begin
      r = push_byte(r, UTF_LEAD3 | {4'b0000, cp[15:12]});
      r = push_byte(r, UTF_CONT | ({2'b00, cp[11:6]} & UTF_MASK));
      r = push_byte(r, UTF_CONT | ({2'b00, cp[5:0]} & UTF_MASK));
    end
    return r;
  endfunction

endpackage

// ===== sv/jsu_front.sv =====
// Front end: escape state machine that turns each input item into a burst command.
module jsu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_take,
  input  jsu_pkg::in_item_t  in_item,
  output logic               cmd_push,
  output jsu_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    RR_NORMAL = 3'b001,
    RR_ESC    = 3'b010,
    RR_HEX    = 3'b100
  } rr_mode_t;

  jsu_pkg::mode_t mode_r, mode_nxt;
  logic [15:0]    cp_r, cp_nxt;
  logic [7:0]     held_r   [3];
  logic [7:0]     held_nxt [3];

  logic [7:0]     b;
  logic           eos;
  logic [15:0]    cp_shift;
  logic [1:0]     hcnt;
  jsu_pkg::mode_t hnext;
  logic [3:0][7:0] elem;
  logic [2:0]     last_pos;

  assign b        = in_item.in_byte;
  assign eos      = in_item.end_of_string;
  assign cp_shift = {cp_r[11:0], jsu_pkg::hex_value(b)};
  assign last_pos = {1'b0, hcnt} + 3'd1;

  always_comb begin
    hcnt  = 2'd0;
    hnext = jsu_pkg::MODE_HEX1;
    case (mode_r)
      jsu_pkg::MODE_HEX1: begin
        hcnt  = 2'd1;
        hnext = jsu_pkg::MODE_HEX2;
      end
      jsu_pkg::MODE_HEX2: begin
        hcnt  = 2'd2;
        hnext = jsu_pkg::MODE_HEX3;
      end
      default: begin
        hcnt  = 2'd0;
        hnext = jsu_pkg::MODE_HEX1;
      end
    endcase
  end

  always_comb begin
    elem[0] = jsu_pkg::CH_U;
    elem[1] = (hcnt == 2'd0) ? b : held_r[0];
    elem[2] = (hcnt == 2'd1) ? b : held_r[1];
    elem[3] = b;
  end

  always_comb begin
    rr_mode_t   rr;
    logic [7:0] e;
    logic       fin;
    rr       = RR_NORMAL;
    e        = 8'h00;
    fin      = 1'b0;
    cmd      = '0;
    cmd.last = eos;
    mode_nxt = mode_r;
    cp_nxt   = cp_r;
    held_nxt = held_r;
    case (mode_r)
      jsu_pkg::MODE_NORMAL: begin
        if (b == jsu_pkg::CH_BSL && !eos) begin
          mode_nxt = jsu_pkg::MODE_ESC;
        end else begin
          cmd = jsu_pkg::push_byte(cmd, b);
        end
      end
      jsu_pkg::MODE_ESC: begin
        mode_nxt = jsu_pkg::MODE_NORMAL;
        if (b == jsu_pkg::CH_U) begin
          if (eos) begin
            cmd = jsu_pkg::push_byte(cmd, jsu_pkg::CH_BSL);
            cmd = jsu_pkg::push_byte(cmd, jsu_pkg::CH_U);
          end else begin
            mode_nxt = jsu_pkg::MODE_HEX0;
            cp_nxt   = '0;
          end
        end else begin
          cmd = jsu_pkg::push_byte(cmd, jsu_pkg::translate(b));
        end
      end
      jsu_pkg::MODE_HEX0, jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
        if (!eos) begin
          cp_nxt         = cp_shift;
          held_nxt[hcnt] = b;
          mode_nxt       = hnext;
        end else begin
          // string cut short inside \u: literal backslash, then replay u, held digits and b
          mode_nxt = jsu_pkg::MODE_NORMAL;
          cp_nxt   = '0;
          cmd      = jsu_pkg::push_byte(cmd, jsu_pkg::CH_BSL);
          for (int i = 0; i < 4; i++) begin
            if (3'(i) <= last_pos) begin
              e   = elem[2'(i)];
              fin = (3'(i) == last_pos);
              case (rr)
                RR_NORMAL: begin
                  if (e == jsu_pkg::CH_BSL && !fin) begin
                    rr = RR_ESC;
                  end else begin
                    cmd = jsu_pkg::push_byte(cmd, e);
                  end
                end
                RR_ESC: begin
                  rr = RR_NORMAL;
                  if (e == jsu_pkg::CH_U) begin
                    if (fin) begin
                      cmd = jsu_pkg::push_byte(cmd, jsu_pkg::CH_BSL);
                      cmd = jsu_pkg::push_byte(cmd, jsu_pkg::CH_U);
                    end else begin
                      rr = RR_HEX;
                    end
                  end else begin
                    cmd = jsu_pkg::push_byte(cmd, jsu_pkg::translate(e));
                  end
                end
                RR_HEX: begin
                  if (fin) begin
                    rr  = RR_NORMAL;
                    cmd = jsu_pkg::push_byte(cmd, jsu_pkg::CH_BSL);
                    cmd = jsu_pkg::push_byte(cmd, jsu_pkg::CH_U);
                    cmd = jsu_pkg::push_byte(cmd, e);
                  end
                end
                default: rr = RR_NORMAL;
              endcase
            end
          end
        end
      end
      jsu_pkg::MODE_HEX3: begin
        mode_nxt = jsu_pkg::MODE_NORMAL;
        cp_nxt   = '0;
        cmd      = jsu_pkg::push_utf8(cmd, cp_shift);
      end
      default: begin
        mode_nxt = jsu_pkg::MODE_NORMAL;
        cp_nxt   = '0;
        cmd      = jsu_pkg::push_byte(cmd, b);
      end
    endcase
  end

  assign cmd_push = in_take && (cmd.cnt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jsu_pkg::MODE_NORMAL;
      cp_r   <= '0;
    end else if (in_take) begin
      mode_r <= mode_nxt;
      cp_r   <= cp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      held_r <= held_nxt;
    end
  end

endmodule

// ===== sv/jsu_fifo.sv =====
// Command queue between the front end and the byte emitter.
module jsu_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  jsu_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output jsu_pkg::cmd_t rd_data,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jsu_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== sv/jsu_back.sv =====
// Back end: holds one burst command and hands out its bytes one item at a time.
module jsu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  jsu_pkg::cmd_t      q_data,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output jsu_pkg::out_item_t out_data
);

  jsu_pkg::cmd_t             cur_r, cur_nxt;
  logic [jsu_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic                      vld_r, vld_nxt;
  logic                      at_end;
  logic                      take;

  assign at_end = (idx_r == cur_r.cnt - jsu_pkg::CNT_W'(1));
  assign take   = vld_r && pop;
  assign q_pop  = !q_empty && (!vld_r || (take && at_end));

  always_comb begin
    cur_nxt = cur_r;
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (q_pop) begin
      cur_nxt = q_data;
      idx_nxt = '0;
      vld_nxt = 1'b1;
    end else if (take) begin
      if (at_end) begin
        vld_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + jsu_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  assign empty             = !vld_r;
  assign out_data.out_byte = cur_r.bytes[idx_r];
  assign out_data.last     = cur_r.last && at_end;

endmodule

// ===== sv/json_string_unescape_top.sv =====
// Top level of the streaming JSON string unescaper with UTF-8 output.
//
//   channel | ports                        | direction | item
//   --------+------------------------------+-----------+-------------------------------
//   input   | push, full, in_data          | in        | raw byte, end-of-string flag
//   result  | empty, pop, out_data         | out       | unescaped byte, last flag
//
// One input item is taken per cycle while the command queue has room; each item
// becomes a command of zero to five bytes, built combinationally.
// The emitter gives one result byte per cycle while pop is high, each item's bytes in turn.
// An item's first byte passes the command queue, then the emitter register, to out_data.
// Synchronous reset clears the escape state, queue pointers and emitter.
// full rises only when FIFO_DEPTH commands wait behind the one being emitted.
module json_string_unescape_top #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  jsu_pkg::in_item_t  in_data,
  output logic               empty,
  input  logic               pop,
  output jsu_pkg::out_item_t out_data
);

  logic          in_take;
  logic          cmd_push;
  jsu_pkg::cmd_t cmd;
  logic          q_empty;
  logic          q_pop;
  jsu_pkg::cmd_t q_data;

  assign in_take = push && !full;

  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_take  (in_take),
    .in_item  (in_data),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  jsu_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  jsu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

endmodule

// ===== sv/jsu_checker.sv =====
// Port-level checks for the JSON string unescaper, bound to the top level.
module jsu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input jsu_pkg::out_item_t out_data
);

  a_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (empty && !full))
    else $error("queue not clear after reset");

  a_full_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !empty)
    else $error("input stalled while no result is shown");

  a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty)
    else $error("waiting result item dropped");

  a_item_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> $stable(out_data))
    else $error("waiting result item changed");

endmodule

bind json_string_unescape_top jsu_checker u_jsu_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);
